FILE: src/lpft_pkg.sv
// Shared types and constants for the LRU page frame tracker.
// Used by lpft_cell and lru_page_frame_tracker_core; depends on nothing.
package lpft_pkg;

  localparam int CFG_W        = 5;
  localparam int FAULT_W      = 32;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // Travels from one cell to the next, most recent end first.
  typedef struct packed {
    logic valid;   // this cell holds a page (after any restart clear)
    logic carry;   // the shift wave reaches the next cell
  } link_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic load;        // a request is being applied this cycle
    logic restart;     // clear all frames before the request
    logic evict_mode;  // the row is full for the current frame limit
  } cell_ctrl_t;

endpackage

FILE: src/lpft_cell.sv
// One frame of the recency-ordered row: holds a page and its valid bit,
// compares against the request and shifts in its neighbor's page. Uses lpft_pkg.
module lpft_cell #(
  parameter int PAGE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lpft_pkg::cell_ctrl_t   ctrl,
  input  logic [PAGE_BITS-1:0]   req_page,
  input  lpft_pkg::link_t        prev,
  input  logic [PAGE_BITS-1:0]   prev_page,
  input  logic                   next_valid,
  output lpft_pkg::link_t        link,
  output logic [PAGE_BITS-1:0]   page,
  output logic                   match,
  output logic                   drop
);
  import lpft_pkg::*;

  logic                 valid;
  logic                 valid_eff;
  logic                 last;
  logic [PAGE_BITS-1:0] page_q;

  assign valid_eff = valid & ~ctrl.restart;
  assign match     = valid_eff & (page_q == req_page);
  // The oldest resident page sits in the last valid cell.
  assign last      = valid_eff & ~next_valid;
  assign drop      = prev.carry & ctrl.evict_mode & last & ~match;

  assign link.valid = valid_eff;
  assign link.carry = prev.carry & valid_eff & ~match & ~(ctrl.evict_mode & last);
  assign page       = page_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= prev.carry ? prev.valid : valid_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && prev.carry) begin
      page_q <= prev_page;
    end
  end

endmodule

FILE: src/lru_page_frame_tracker_core.sv
// Top level of the LRU page frame tracker: a row of lpft_cell frames kept in
// recency order, the resident and fault counters, and the result register. Uses lpft_pkg.
//
// Resident pages sit in a row of FRAMES cells ordered from most recent (cell 0)
// to least recent (the last valid cell). Each request is compared against all
// cells at once; on a hit the cells in front of the match shift back by one and
// the page moves to cell 0, on a miss every resident cell shifts back and the
// page enters at cell 0, either filling the next free cell or pushing the
// oldest page out as the evicted page when the row holds frames_in_use pages
// or more. One request is taken per clock cycle, and its result appears in
// the output register on the next cycle; the combinational compare-and-shift
// across the cell row sets that rate, and a held result only stalls new
// requests while out_ready stays low. A restart flag clears the frames and
// the fault count as part of its own request. frames_in_use is clamped to the
// range 1 to FRAMES and should only be written while the block is idle.
module lru_page_frame_tracker_core #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lpft_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [PAGE_BITS-1:0]           page_number,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           fault,
  output logic                           evicted_valid,
  output logic [PAGE_BITS-1:0]           evicted_page,
  output logic [lpft_pkg::FAULT_W-1:0]   fault_total
);
  import lpft_pkg::*;

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]     resident_count;
  logic [CNT_W-1:0]     resident_count_next;
  logic [FAULT_W-1:0]   fault_counter;
  logic [FAULT_W-1:0]   fault_counter_next;

  logic                 accept;
  logic [CMP_W-1:0]     limit;
  logic [CMP_W-1:0]     count_eff;
  logic [FAULT_W-1:0]   faults_eff;
  cell_ctrl_t           ctrl;

  link_t                link      [FRAMES];
  logic [PAGE_BITS-1:0] cell_page [FRAMES];
  logic [FRAMES-1:0]    match;
  logic [FRAMES-1:0]    drop;

  logic                 miss;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // Clamp the configured frame count into 1 .. FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      limit = CMP_W'(1);
    end else if (CMP_W'(frames_in_use) > CMP_W'(FRAMES)) begin
      limit = CMP_W'(FRAMES);
    end else begin
      limit = CMP_W'(frames_in_use);
    end
  end

  assign count_eff  = restart ? '0 : CMP_W'(resident_count);
  assign faults_eff = restart ? '0 : fault_counter;

  assign ctrl.load       = accept;
  assign ctrl.restart    = restart;
  assign ctrl.evict_mode = (count_eff >= limit);

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    link_t                prev;
    logic [PAGE_BITS-1:0] prev_page;
    logic                 next_valid;

    if (i == 0) begin : g_head
      assign prev.valid = 1'b1;
      assign prev.carry = 1'b1;
      assign prev_page  = page_number;
    end else begin : g_body
      assign prev      = link[i-1];
      assign prev_page = cell_page[i-1];
    end

    if (i == FRAMES - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_valid = link[i+1].valid;
    end

    lpft_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .req_page   (page_number),
      .prev       (prev),
      .prev_page  (prev_page),
      .next_valid (next_valid),
      .link       (link[i]),
      .page       (cell_page[i]),
      .match      (match[i]),
      .drop       (drop[i])
    );
  end

  assign miss     = ~(|match);
  assign ev_valid = |drop;

  // At most one cell drops its page, so an AND-OR select is enough.
  always_comb begin
    ev_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      ev_page = ev_page | (cell_page[i] & {PAGE_BITS{drop[i]}});
    end
  end

  always_comb begin
    resident_count_next = CNT_W'(count_eff);
    if (miss && !ctrl.evict_mode) begin
      resident_count_next = CNT_W'(count_eff) + CNT_W'(1);
    end
    fault_counter_next = faults_eff;
    if (miss && (faults_eff != '1)) begin
      fault_counter_next = faults_eff + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use  <= FRAMES_RESET;
      resident_count <= '0;
      fault_counter  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      if (accept) begin
        resident_count <= resident_count_next;
        fault_counter  <= fault_counter_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fault         <= miss;
      evicted_valid <= ev_valid;
      evicted_page  <= ev_page;
      fault_total   <= fault_counter_next;
    end
  end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for lru_page_frame_tracker_core, LRU page replacement over 16 frames.
// Depends on lpft_pkg and the core; a behavioral LRU tracker here predicts all but typed rows.
module tb;
  import lpft_pkg::*;

  localparam int NFRAMES     = 16;
  localparam int PBITS       = 16;
  localparam int PHASE_REFS  = 162;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              fault;
    logic              ev_valid;
    logic [PBITS-1:0]  ev_page;
    logic [FAULT_W-1:0] total;
  } outcome_t;

  typedef struct packed {
    logic              set_cfg;
    logic [CFG_W-1:0]  cfg;
    logic [PBITS-1:0]  page;
    logic              restart;
    logic              typed;
    outcome_t          want;
  } plan_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PBITS-1:0]   page_number = '0;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               fault;
  logic               evicted_valid;
  logic [PBITS-1:0]   evicted_page;
  logic [FAULT_W-1:0] fault_total;

  // Shadow copy of the frame set.
  logic [PBITS-1:0]   shadow_page [NFRAMES];
  logic               shadow_valid [NFRAMES];
  int unsigned        shadow_rank [NFRAMES];
  int unsigned        shadow_resident;
  logic [FAULT_W-1:0] shadow_faults;
  logic [CFG_W-1:0]   frame_limit;

  outcome_t    awaited_outcomes [$];
  outcome_t    due;
  plan_row_t   plan [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned hit_count = 0;
  int unsigned evict_count = 0;
  int unsigned restart_count = 0;
  int unsigned ref_count = 0;
  int unsigned cycles = 0;
  logic        calm = 1'b0;

  lru_page_frame_tracker_core #(
    .FRAMES(NFRAMES),
    .PAGE_BITS(PBITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .page_number(page_number),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fault(fault),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .fault_total(fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_limit(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > NFRAMES) return NFRAMES;
    return v;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < NFRAMES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
      shadow_page[i] = '0;
    end
    shadow_resident = 0;
    shadow_faults = '0;
  endfunction

  // Applies one request to the shadow frame set and returns what the block should report.
  function automatic outcome_t touch_page(input logic [PBITS-1:0] pg, input logic rs);
    outcome_t    o;
    int          hit;
    int          slot;
    int unsigned lim;
    int unsigned oldest;
    int unsigned r;
    o = '0;
    hit = -1;
    slot = -1;
    oldest = 0;
    if (rs) clear_shadow();
    lim = clamp_limit(frame_limit);
    for (int i = 0; i < NFRAMES; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_page[i] == pg) hit = i;
    end
    if (hit >= 0) begin
      r = shadow_rank[hit];
      for (int i = 0; i < NFRAMES; i++) begin
        if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
      end
      shadow_rank[hit] = 0;
    end else begin
      o.fault = 1'b1;
      if (shadow_faults != '1) shadow_faults++;
      if (shadow_resident < lim) begin
        for (int i = 0; i < NFRAMES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < NFRAMES; i++) begin
          if (shadow_valid[i]) shadow_rank[i]++;
        end
        shadow_valid[slot] = 1'b1;
        shadow_resident++;
      end else begin
        // The row is at or over its limit, so the least recently used page goes.
        for (int i = 0; i < NFRAMES; i++) begin
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > oldest)) begin
            slot = i;
            oldest = shadow_rank[i];
          end
        end
        o.ev_valid = 1'b1;
        o.ev_page = shadow_page[slot];
        for (int i = 0; i < NFRAMES; i++) begin
          if (shadow_valid[i]) shadow_rank[i]++;
        end
      end
      shadow_page[slot] = pg;
      shadow_rank[slot] = 0;
    end
    o.total = shadow_faults;
    return o;
  endfunction

  function automatic plan_row_t plan_row(input logic sc, input logic [CFG_W-1:0] cv,
                                         input logic [PBITS-1:0] pg, input logic rs,
                                         input logic ty, input logic f, input logic ev,
                                         input logic [PBITS-1:0] evp,
                                         input logic [FAULT_W-1:0] tot);
    plan_row_t p;
    p.set_cfg = sc;
    p.cfg = cv;
    p.page = pg;
    p.restart = rs;
    p.typed = ty;
    p.want.fault = f;
    p.want.ev_valid = ev;
    p.want.ev_page = evp;
    p.want.total = tot;
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input logic [FAULT_W-1:0] got,
                               input logic [FAULT_W-1:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic issue_ref(input logic [PBITS-1:0] pg, input logic rs, input logic typed,
                           input outcome_t want);
    outcome_t pred;
    in_valid <= 1'b1;
    page_number <= pg;
    restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = touch_page(pg, rs);
    awaited_outcomes.push_back(typed ? want : pred);
    ref_count++;
    if (!pred.fault) hit_count++;
    if (pred.ev_valid) evict_count++;
    if (rs) restart_count++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = $urandom_range(1, 13);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] v);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_limit = v;
  endtask

  // Compare each delivered result against the oldest outstanding one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch("arrived with no request outstanding", fault_total, '0);
      end else begin
        due = awaited_outcomes.pop_front();
        if (fault !== due.fault) flag_mismatch("fault", fault, due.fault);
        if (evicted_valid !== due.ev_valid)
          flag_mismatch("evicted_valid", evicted_valid, due.ev_valid);
        if (evicted_page !== due.ev_page)
          flag_mismatch("evicted_page", evicted_page, due.ev_page);
        if (fault_total !== due.total) flag_mismatch("fault_total", fault_total, due.total);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycles, awaited_outcomes.size());
      $display("lru_page_frame_tracker_core: mismatch");
      $finish;
    end
  end

  // Result side: random stalls except in calm phases.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic [CFG_W-1:0] limits [12];
    outcome_t         none;
    logic [PBITS-1:0] hot_base;
    logic [PBITS-1:0] pg;
    logic             rs;
    int unsigned      hot_span;
    int unsigned      pick;

    limits = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd31, 5'd8, 5'd2, 5'd17, 5'd16, 5'd3, 5'd12, 5'd5};
    none = '0;
    clear_shadow();
    frame_limit = FRAMES_RESET;

    // Typed rows: cold misses, a hit, a restart on a resident page, the zero and
    // oversized limits, and a limit lowered below the number of resident pages.
    plan.push_back(plan_row(0, 5'd0, 16'h0000, 0, 1, 1, 0, 16'h0000, 1));
    plan.push_back(plan_row(0, 5'd0, 16'hFFFF, 0, 1, 1, 0, 16'h0000, 2));
    plan.push_back(plan_row(0, 5'd0, 16'h0000, 0, 1, 0, 0, 16'h0000, 2));
    plan.push_back(plan_row(0, 5'd0, 16'hFFFF, 1, 1, 1, 0, 16'h0000, 1));
    plan.push_back(plan_row(1, 5'd0, 16'h1234, 0, 1, 1, 1, 16'hFFFF, 2));
    plan.push_back(plan_row(0, 5'd0, 16'h1234, 0, 1, 0, 0, 16'h0000, 2));
    plan.push_back(plan_row(0, 5'd0, 16'hAAAA, 0, 1, 1, 1, 16'h1234, 3));
    plan.push_back(plan_row(1, 5'd31, 16'h5555, 0, 1, 1, 0, 16'h0000, 4));
    plan.push_back(plan_row(0, 5'd0, 16'h0001, 0, 0, 0, 0, 16'h0000, 0));
    plan.push_back(plan_row(0, 5'd0, 16'h0002, 0, 0, 0, 0, 16'h0000, 0));
    plan.push_back(plan_row(0, 5'd0, 16'h0003, 0, 0, 0, 0, 16'h0000, 0));
    plan.push_back(plan_row(1, 5'd2, 16'h0002, 0, 0, 0, 0, 16'h0000, 0));
    plan.push_back(plan_row(0, 5'd0, 16'h7777, 0, 1, 1, 1, 16'hAAAA, 8));
    plan.push_back(plan_row(0, 5'd0, 16'h5555, 0, 0, 0, 0, 16'h0000, 0));
    plan.push_back(plan_row(0, 5'd0, 16'h8888, 0, 0, 0, 0, 16'h0000, 0));
    plan.push_back(plan_row(1, 5'd17, 16'h0001, 1, 1, 1, 0, 16'h0000, 1));
    plan.push_back(plan_row(0, 5'd0, 16'h8000, 0, 0, 0, 0, 16'h0000, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_cfg) set_frames(plan[i].cfg);
      issue_ref(plan[i].page, plan[i].restart, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 12; p++) begin
      calm = (p == 5 || p == 11);
      set_frames(limits[p]);
      hot_base = $urandom_range(0, 65535);
      hot_span = clamp_limit(limits[p]);
      hot_span = hot_span + $urandom_range(0, hot_span + 2);
      for (int n = 0; n < PHASE_REFS; n++) begin
        if (!calm && $urandom_range(0, 5) == 0) sender_gap();
        if (!calm && $urandom_range(0, 199) == 0) drain_idle();
        pick = $urandom_range(0, 99);
        // Mostly a working set a little larger than the frame limit, so hits,
        // fills and evictions all occur; the rest spans the whole page range.
        if (pick < 78) pg = hot_base + PBITS'($urandom_range(0, hot_span - 1));
        else pg = PBITS'($urandom);
        rs = ($urandom_range(0, 39) == 0);
        issue_ref(pg, rs, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d page requests over 12 frame limits and checked %0d results.",
             ref_count, results_seen);
    $display("Seen: %0d hits, %0d evictions, %0d restarts, %0d field mismatches.",
             hit_count, evict_count, restart_count, mismatch_count);
    if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
      $display("lru_page_frame_tracker_core: match");
    end else begin
      $display("lru_page_frame_tracker_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: lru_page_frame_tracker_core.f
src/lpft_pkg.sv
src/lpft_cell.sv
src/lru_page_frame_tracker_core.sv
sim/tb.sv
